// File: hdl/srtf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the SRTF tick scheduler.
// No dependencies; used by every module of the block.
package srtf_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic REG_PROCESS_COUNT = 1'b0;
  localparam logic REG_IDLE_LIMIT    = 1'b1;

  localparam logic [4:0] PROCESS_COUNT_RESET = 5'd0;
  localparam logic [3:0] IDLE_LIMIT_RESET    = 4'd5;
  localparam logic [3:0] IDLE_RUN_MAX        = 4'd15;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } item_t;

  typedef struct packed {
    logic [7:0]  run_id;
    logic        idle;
    logic        switched;
    logic        finished;
    logic        all_done;
    logic        halted;
    logic [31:0] time_now;
  } result_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic scan_done;
  } sts_t;

endpackage

// File: hdl/srtf_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the SRTF tick scheduler.
// Depends on srtf_pkg; drives the datapath through cmd_t and reads sts_t.
module srtf_ctrl
  import srtf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREP   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.prep    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.is_clear ? ST_COMMIT : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

endmodule

// File: hdl/srtf_dp.sv
`timescale 1ns / 1ps
// Slot tables, scan compare and tick update of the SRTF tick scheduler.
// Depends on srtf_pkg; commanded by srtf_ctrl.
module srtf_dp
  import srtf_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic [4:0] process_count,
  input  logic [3:0] idle_limit,
  input  cmd_t       cmd,
  output sts_t       sts,
  output result_t    result
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = (CW > 5) ? CW : 5;

  item_t item_q;

  logic [15:0] rem_mem [SLOTS];
  logic [15:0] arr_mem [SLOTS];
  logic [7:0]  id_mem  [SLOTS];
  logic [SLOTS-1:0] work;

  logic [31:0]   tick_count;
  logic [3:0]    idle_run;
  logic          last_valid;
  logic [SW-1:0] last_runner;
  logic          stopped;

  logic [NW-1:0] idx;
  logic          rd_vld;
  logic          rd_work;
  logic [SW-1:0] rd_idx;
  logic [15:0]   rd_rem;
  logic [15:0]   rd_arr;
  logic [7:0]    rd_id;

  logic          found;
  logic [SW-1:0] best_idx;
  logic [15:0]   best_rem;
  logic [15:0]   best_arr;
  logic [7:0]    best_id;
  logic [CW-1:0] cnt;

  logic [NW-1:0] pc_ext;
  logic [NW-1:0] active_n;
  logic [NW-1:0] slot_ext;
  logic [SW-1:0] ld_idx;
  logic          ld_ok;
  logic          is_load;
  logic          is_tick;
  logic          is_clear;
  logic          issue;
  logic          cand;
  logic          better;

  logic          do_tick;
  logic          hit;
  logic          fin;
  logic [15:0]   rem_dec;
  logic [3:0]    lim;
  logic [3:0]    idle_run_inc;
  logic [31:0]   tick_inc;
  logic [31:0]   tick_count_next;
  logic [3:0]    idle_run_next;
  logic          stopped_next;
  logic          rem_we;
  logic [SW-1:0] rem_waddr;
  logic [15:0]   rem_wdata;

  assign is_load  = (item_q.action == ACT_LOAD);
  assign is_tick  = (item_q.action == ACT_TICK);
  assign is_clear = (item_q.action == ACT_CLEAR);

  assign pc_ext   = NW'(process_count);
  assign active_n = (pc_ext > NW'(SLOTS)) ? NW'(SLOTS) : pc_ext;
  assign slot_ext = NW'(item_q.slot);
  assign ld_idx   = slot_ext[SW-1:0];
  assign ld_ok    = cmd.prep && is_load && (slot_ext < NW'(SLOTS));

  assign issue = cmd.scan && (idx < active_n);
  assign sts.is_clear  = is_clear;
  assign sts.scan_done = (idx >= active_n) && !rd_vld;

  assign cand   = rd_vld && rd_work && ({16'd0, rd_arr} <= tick_count);
  assign better = !found || (rd_rem < best_rem) ||
                  ((rd_rem == best_rem) && (rd_arr < best_arr));

  assign do_tick      = is_tick && !stopped;
  assign hit          = do_tick && found;
  assign rem_dec      = best_rem - 16'd1;
  assign fin          = hit && (rem_dec == 16'd0);
  assign lim          = (idle_limit == 4'd0) ? 4'd1 : idle_limit;
  assign idle_run_inc = (idle_run != IDLE_RUN_MAX) ? idle_run + 4'd1 : IDLE_RUN_MAX;
  assign tick_inc     = (tick_count != 32'hFFFF_FFFF) ? tick_count + 32'd1 : tick_count;

  always_comb begin
    tick_count_next = tick_count;
    idle_run_next   = idle_run;
    stopped_next    = stopped;
    if (hit) begin
      idle_run_next   = 4'd0;
      tick_count_next = tick_inc;
    end else if (do_tick) begin
      idle_run_next = idle_run_inc;
      if (idle_run_inc >= lim) begin
        stopped_next = 1'b1;
      end else begin
        tick_count_next = tick_inc;
      end
    end
  end

  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = ld_idx;
    rem_wdata = item_q.burst;
    if (ld_ok) begin
      rem_we = 1'b1;
    end else if (cmd.commit && hit) begin
      rem_we    = 1'b1;
      rem_waddr = best_idx;
      rem_wdata = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (ld_ok) begin
      arr_mem[ld_idx] <= item_q.arrival;
      id_mem[ld_idx]  <= item_q.proc_id;
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (issue) begin
      rd_rem <= rem_mem[idx[SW-1:0]];
      rd_arr <= arr_mem[idx[SW-1:0]];
      rd_id  <= id_mem[idx[SW-1:0]];
      rd_idx <= idx[SW-1:0];
    end
    if (cand && better) begin
      best_idx <= rd_idx;
      best_rem <= rd_rem;
      best_arr <= rd_arr;
      best_id  <= rd_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work        <= '0;
      tick_count  <= '0;
      idle_run    <= '0;
      last_valid  <= 1'b0;
      last_runner <= '0;
      stopped     <= 1'b0;
      idx         <= '0;
      rd_vld      <= 1'b0;
      rd_work     <= 1'b0;
      found       <= 1'b0;
      cnt         <= '0;
      result      <= '0;
    end else begin
      if (cmd.prep) begin
        idx    <= '0;
        rd_vld <= 1'b0;
        found  <= 1'b0;
        cnt    <= '0;
        if (is_clear) begin
          work        <= '0;
          tick_count  <= '0;
          idle_run    <= '0;
          last_valid  <= 1'b0;
          last_runner <= '0;
          stopped     <= 1'b0;
        end
        if (ld_ok) begin
          work[ld_idx] <= (item_q.burst != 16'd0);
        end
      end
      if (cmd.scan) begin
        rd_vld <= issue;
        if (issue) begin
          idx     <= idx + NW'(1);
          rd_work <= work[idx[SW-1:0]];
        end
        if (rd_vld && rd_work) begin
          cnt <= cnt + CW'(1);
        end
        if (cand) begin
          found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        tick_count <= tick_count_next;
        idle_run   <= idle_run_next;
        stopped    <= stopped_next;
        if (hit) begin
          if (fin) begin
            work[best_idx] <= 1'b0;
            last_valid     <= 1'b0;
            last_runner    <= '0;
          end else begin
            last_valid  <= 1'b1;
            last_runner <= best_idx;
          end
        end
        result.run_id   <= hit ? best_id : 8'd0;
        result.idle     <= is_tick && !hit;
        result.switched <= hit && (!last_valid || (last_runner != best_idx));
        result.finished <= fin;
        result.all_done <= fin ? (cnt == CW'(1)) : (cnt == '0);
        result.halted   <= stopped_next;
        result.time_now <= tick_count_next;
      end
    end
  end

endmodule

// File: hdl/srtf_tick_scheduler.sv
`timescale 1ns / 1ps
// SRTF tick scheduler top level: configuration registers, controller and datapath.
// The scan reads one slot per cycle over the N active slots, N = min of process_count
// and SLOTS; a clear action skips the scan. A new start transfer is taken only when idle,
// and can be taken while the result strobe is high. The receiver cannot stall.
// Reset: all slots empty, time 0, not halted, process_count 0, idle_limit 5.
module srtf_tick_scheduler
  import srtf_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] process_count;
  logic [3:0] idle_limit;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= PROCESS_COUNT_RESET;
      idle_limit    <= IDLE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_PROCESS_COUNT: process_count <= pwdata[4:0];
        REG_IDLE_LIMIT:    idle_limit    <= pwdata[3:0];
        default:           process_count <= process_count;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PROCESS_COUNT: prdata = {27'd0, process_count};
      REG_IDLE_LIMIT:    prdata = {28'd0, idle_limit};
      default:           prdata = 32'd0;
    endcase
  end

  srtf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  srtf_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .process_count (process_count),
    .idle_limit    (idle_limit),
    .cmd           (cmd),
    .sts           (sts),
    .result        (result)
  );

endmodule

// File: tb/sv/srtf_tick_scheduler_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for srtf_tick_scheduler: a directed table, then random
// scheduling episodes, each result checked against the table or an in-bench predictor.
// Depends on srtf_pkg and the scheduler RTL.
module srtf_tick_scheduler_tb
  import srtf_pkg::*;
();

  localparam int NSLOT = SLOTS_DEFAULT;
  localparam int ITEM_TARGET = 1550;
  localparam int QUIET_TAIL = 200;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_PROCESS_COUNT = {REG_PROCESS_COUNT, 2'b00};
  localparam logic [2:0] ADDR_IDLE_LIMIT = {REG_IDLE_LIMIT, 2'b00};

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [31:0] data;
    item_t       it;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item_in;
  logic        done;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  srtf_tick_scheduler #(.SLOTS(NSLOT)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item_in),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // scheduler shadow state
  logic [15:0] arr_tbl [NSLOT];
  logic [15:0] rem_tbl [NSLOT];
  logic [7:0]  id_tbl [NSLOT];
  logic [31:0] clock_ticks;
  int          idle_streak;
  bit          runner_valid;
  int          runner_slot;
  bit          halted_st;
  int          proc_count_cfg;
  int          idle_limit_cfg;

  result_t     due_results[$];
  result_t     last_pred;
  plan_row_t   plan[$];
  int          sent_total = 0;
  int          results_seen = 0;
  int          completions = 0;
  int          halted_ticks = 0;
  int          errors = 0;
  int          cycles = 0;

  function automatic void wipe_sched();
    for (int i = 0; i < NSLOT; i++) begin
      arr_tbl[i] = '0;
      rem_tbl[i] = '0;
      id_tbl[i] = '0;
    end
    clock_ticks = '0;
    idle_streak = 0;
    runner_valid = 1'b0;
    runner_slot = 0;
    halted_st = 1'b0;
  endfunction

  function automatic result_t schedule_step(item_t it);
    result_t r;
    int n;
    int pick;
    int lim;
    bit any;
    r = '0;
    n = (proc_count_cfg > NSLOT) ? NSLOT : proc_count_cfg;
    case (it.action)
      ACT_LOAD: begin
        arr_tbl[it.slot] = it.arrival;
        rem_tbl[it.slot] = it.burst;
        id_tbl[it.slot] = it.proc_id;
      end
      ACT_CLEAR: wipe_sched();
      ACT_TICK: begin
        if (halted_st) begin
          r.idle = 1'b1;
        end else begin
          any = 1'b0;
          pick = 0;
          for (int i = 0; i < n; i++) begin
            if (rem_tbl[i] != 0 && {16'd0, arr_tbl[i]} <= clock_ticks) begin
              if (!any || rem_tbl[i] < rem_tbl[pick] ||
                  (rem_tbl[i] == rem_tbl[pick] && arr_tbl[i] < arr_tbl[pick])) begin
                pick = i;
                any = 1'b1;
              end
            end
          end
          if (!any) begin
            lim = (idle_limit_cfg == 0) ? 1 : idle_limit_cfg;
            r.idle = 1'b1;
            if (idle_streak < IDLE_RUN_MAX) idle_streak++;
            if (idle_streak >= lim) halted_st = 1'b1;
            else if (clock_ticks != '1) clock_ticks++;
          end else begin
            idle_streak = 0;
            r.run_id = id_tbl[pick];
            r.switched = !runner_valid || runner_slot != pick;
            rem_tbl[pick] = rem_tbl[pick] - 16'd1;
            if (clock_ticks != '1) clock_ticks++;
            if (rem_tbl[pick] == 0) begin
              r.finished = 1'b1;
              runner_valid = 1'b0;
              runner_slot = 0;
            end else begin
              runner_valid = 1'b1;
              runner_slot = pick;
            end
          end
        end
      end
      default: ;
    endcase
    r.all_done = 1'b1;
    for (int i = 0; i < n; i++) if (rem_tbl[i] != 0) r.all_done = 1'b0;
    r.halted = halted_st;
    r.time_now = clock_ticks;
    return r;
  endfunction

  function automatic item_t mk_item(logic [1:0] act, logic [3:0] slot, logic [7:0] id,
                                    logic [15:0] arr, logic [15:0] burst);
    item_t it;
    it.action = act;
    it.slot = slot;
    it.proc_id = id;
    it.arrival = arr;
    it.burst = burst;
    return it;
  endfunction

  function automatic result_t res(logic [7:0] rid, logic idl, logic sw, logic fin,
                                  logic ad, logic h, logic [31:0] t);
    result_t r;
    r.run_id = rid;
    r.idle = idl;
    r.switched = sw;
    r.finished = fin;
    r.all_done = ad;
    r.halted = h;
    r.time_now = t;
    return r;
  endfunction

  function automatic item_t make_load(int s);
    int r;
    logic [15:0] arr;
    logic [15:0] burst;
    arr = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 12))
                                       : 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 10) burst = '0;
    else if (r < 85) burst = 16'($urandom_range(1, 6));
    else burst = 16'($urandom_range(0, 65535));
    return mk_item(ACT_LOAD, 4'(s), 8'($urandom_range(0, 255)), arr, burst);
  endfunction

  function automatic void plan_cfg(logic [2:0] addr, logic [31:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.addr = addr;
    row.data = data;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(item_t it, bit typed, result_t want);
    plan_row_t row;
    row = '{default: '0};
    row.it = it;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  task automatic flag_error(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (due_results.size() != 0 || busy);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    drain();
    repeat (2) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_PROCESS_COUNT) proc_count_cfg = int'(data[4:0]);
    else idle_limit_cfg = int'(data[3:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t predicted;
    start <= 1'b1;
    item_in <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = schedule_step(it);
    due_results.push_back(typed ? want : predicted);
    last_pred = predicted;
    if (it.action != ACT_UNUSED) sent_total++;
    @(negedge clk);
  endtask

  task automatic pace();
    if (sent_total < ITEM_TARGET - QUIET_TAIL) begin
      if ($urandom_range(0, 99) < 25) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else if ($urandom_range(0, 99) < 2) begin
        drain();
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      results_seen++;
      if (due_results.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = due_results.pop_front();
        check_field("run_id", 32'(result.run_id), 32'(want.run_id));
        check_field("idle", 32'(result.idle), 32'(want.idle));
        check_field("switched", 32'(result.switched), 32'(want.switched));
        check_field("finished", 32'(result.finished), 32'(want.finished));
        check_field("all_done", 32'(result.all_done), 32'(want.all_done));
        check_field("halted", 32'(result.halted), 32'(want.halted));
        check_field("time_now", result.time_now, want.time_now);
        if (want.finished) completions++;
        if (want.halted && want.idle) halted_ticks++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[srtf_tick_scheduler] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int pc;
    int lim;
    int n;
    int r;
    int ticks;
    int tail;
    int w;
    rst = 1'b1;
    start = 1'b0;
    item_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    wipe_sched();
    proc_count_cfg = int'(PROCESS_COUNT_RESET);
    idle_limit_cfg = int'(IDLE_LIMIT_RESET);

    plan_item(mk_item(ACT_CLEAR, 4'h0, 8'h00, 16'h0000, 16'h0000), 1, res(0, 0, 0, 0, 1, 0, 0));
    plan_item(mk_item(ACT_TICK, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF), 1, res(0, 1, 0, 0, 1, 0, 1));
    plan_item(mk_item(ACT_UNUSED, 4'h3, 8'h12, 16'h0000, 16'h0001), 1, res(0, 0, 0, 0, 1, 0, 1));
    plan_cfg(ADDR_PROCESS_COUNT, 32'd16);
    plan_item(mk_item(ACT_LOAD, 4'h0, 8'hFF, 16'h0000, 16'hFFFF), 1, res(0, 0, 0, 0, 0, 0, 1));
    plan_item(mk_item(ACT_LOAD, 4'hF, 8'h00, 16'hFFFF, 16'h0001), 0, '0);
    plan_item(mk_item(ACT_LOAD, 4'h1, 8'h5A, 16'h0001, 16'h0002), 0, '0);
    plan_item(mk_item(ACT_LOAD, 4'h2, 8'hA5, 16'h0000, 16'h0002), 0, '0);
    plan_item(mk_item(ACT_LOAD, 4'h3, 8'h3C, 16'h0000, 16'h0002), 0, '0);
    repeat (6) plan_item(mk_item(ACT_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000), 0, '0);
    plan_item(mk_item(ACT_LOAD, 4'h5, 8'h77, 16'h0000, 16'h0001), 0, '0);
    plan_item(mk_item(ACT_LOAD, 4'h4, 8'h11, 16'h0000, 16'h0000), 0, '0);
    repeat (2) plan_item(mk_item(ACT_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000), 0, '0);
    plan_cfg(ADDR_PROCESS_COUNT, 32'd31);
    repeat (2) plan_item(mk_item(ACT_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000), 0, '0);
    plan_cfg(ADDR_IDLE_LIMIT, 32'd0);
    plan_item(mk_item(ACT_CLEAR, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF), 1, res(0, 0, 0, 0, 1, 0, 0));
    plan_item(mk_item(ACT_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000), 1, res(0, 1, 0, 0, 1, 1, 0));
    plan_item(mk_item(ACT_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000), 1, res(0, 1, 0, 0, 1, 1, 0));
    plan_item(mk_item(ACT_LOAD, 4'h0, 8'h01, 16'h0000, 16'h0003), 1, res(0, 0, 0, 0, 0, 1, 0));
    plan_item(mk_item(ACT_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000), 1, res(0, 1, 0, 0, 0, 1, 0));
    plan_item(mk_item(ACT_CLEAR, 4'h0, 8'h00, 16'h0000, 16'h0000), 1, res(0, 0, 0, 0, 1, 0, 0));
    plan_cfg(ADDR_IDLE_LIMIT, 32'd15);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].addr, plan[k].data);
      else send_item(plan[k].it, plan[k].typed, plan[k].want);
    end

    while (sent_total < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) pc = 0;
      else if (r < 20) pc = NSLOT;
      else if (r < 26) pc = $urandom_range(17, 31);
      else pc = $urandom_range(1, 10);
      r = $urandom_range(0, 99);
      if (r < 10) lim = 0;
      else if (r < 20) lim = 15;
      else lim = $urandom_range(1, 6);
      write_reg(ADDR_PROCESS_COUNT, pc);
      write_reg(ADDR_IDLE_LIMIT, lim);
      n = (pc > NSLOT) ? NSLOT : pc;

      pace();
      send_item(mk_item(ACT_CLEAR, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))), 0, '0);
      for (int s = 0; s < NSLOT; s++) begin
        if ((s < n && $urandom_range(0, 99) < 85) || $urandom_range(0, 99) < 8) begin
          pace();
          send_item(make_load(s), 0, '0);
        end
      end

      ticks = 0;
      tail = $urandom_range(1, 3);
      while (ticks < 60 && sent_total < ITEM_TARGET) begin
        pace();
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_item(mk_item(ACT_LOAD, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))),
                    0, '0);
        end else if (r < 6) begin
          send_item(mk_item(ACT_UNUSED, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))),
                    0, '0);
        end else if (r < 7) begin
          send_item(mk_item(ACT_CLEAR, 4'h0, 8'h00, 16'h0000, 16'h0000), 0, '0);
        end else begin
          send_item(mk_item(ACT_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))),
                    0, '0);
          ticks++;
          if (last_pred.all_done || last_pred.halted) begin
            if (tail == 0) break;
            tail--;
          end
        end
      end
    end

    start <= 1'b0;
    for (w = 0; w < 5000 && due_results.size() != 0; w++) @(negedge clk);
    repeat (40) @(negedge clk);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", due_results.size()));

    $display("run: %0d transfers sent, %0d results checked", sent_total, results_seen);
    $display("run: %0d completions, %0d ticks while halted or halting", completions,
             halted_ticks);
    if (errors == 0) begin
      $display("[srtf_tick_scheduler] OK");
    end else begin
      $display("[srtf_tick_scheduler] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/srtf_pkg.sv
hdl/srtf_ctrl.sv
hdl/srtf_dp.sv
hdl/srtf_tick_scheduler.sv
tb/sv/srtf_tick_scheduler_tb.sv
